[sv/pdnc_pkg.sv]
// Shared types and constants for the perspective divide / near clip unit.
package pdnc_pkg;

   localparam int REG_W   = 32;  // configuration register and coordinate port width
   localparam int DEPTH_W = 33;  // exact difference of two 32-bit values
   localparam int ADDR_W  = 3;

   typedef enum logic [ADDR_W-1:0] {
      REG_CLIP_ENABLE  = 3'd0,
      REG_NEAR_PLANE   = 3'd1,
      REG_DEPTH_OFFSET = 3'd2,
      REG_CLIP_MARKER  = 3'd3,
      REG_CLIP_NUDGE   = 3'd4
   } reg_index_type;

   localparam logic              RST_CLIP_ENABLE  = 1'b1;
   localparam logic [REG_W-1:0]  RST_NEAR_PLANE   = 32'sd1;
   localparam logic [REG_W-1:0]  RST_DEPTH_OFFSET = 32'sd0;
   localparam logic [REG_W-1:0]  RST_CLIP_MARKER  = -32'sd5000;
   localparam logic [REG_W-1:0]  RST_CLIP_NUDGE   = -32'sd5001;

   // Per-vertex side info that rides along the divider chain.
   typedef struct packed {
      logic               neg_x;
      logic               neg_y;
      logic               zero_div;
      logic               clip;
      logic               last;
      logic [DEPTH_W-1:0] depth;
   } side_type;

endpackage

[sv/pdnc_cell.sv]
// One restoring-division step for the x and y lanes, with its pipeline register.
module pdnc_cell import pdnc_pkg::*; #(
   parameter int W = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         up_valid,
   output logic         up_ready,
   input  logic [W-1:0] up_div,
   input  logic [W-1:0] up_xrem,
   input  logic [W-1:0] up_xa,
   input  logic [W-1:0] up_yrem,
   input  logic [W-1:0] up_ya,
   input  side_type     up_side,
   output logic         dn_valid,
   input  logic         dn_ready,
   output logic [W-1:0] dn_div,
   output logic [W-1:0] dn_xrem,
   output logic [W-1:0] dn_xa,
   output logic [W-1:0] dn_yrem,
   output logic [W-1:0] dn_ya,
   output side_type     dn_side
);

   logic         valid_ff;
   logic [W-1:0] div_ff, xrem_ff, xa_ff, yrem_ff, ya_ff;
   side_type     side_ff;

   logic [W:0]   xt, xd, yt, yd;
   logic [W-1:0] xrem_in, xa_in, yrem_in, ya_in;

   // shift next dividend bit into the partial remainder, try subtracting
   assign xt = {up_xrem, up_xa[W-1]};
   assign yt = {up_yrem, up_ya[W-1]};
   assign xd = xt - {1'b0, up_div};
   assign yd = yt - {1'b0, up_div};

   always_comb begin
      xrem_in = xd[W] ? xt[W-1:0] : xd[W-1:0];
      yrem_in = yd[W] ? yt[W-1:0] : yd[W-1:0];
      xa_in   = {up_xa[W-2:0], ~xd[W]};
      ya_in   = {up_ya[W-2:0], ~yd[W]};
   end

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         div_ff  <= up_div;
         xrem_ff <= xrem_in;
         xa_ff   <= xa_in;
         yrem_ff <= yrem_in;
         ya_ff   <= ya_in;
         side_ff <= up_side;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_div   = div_ff;
   assign dn_xrem  = xrem_ff;
   assign dn_xa    = xa_ff;
   assign dn_yrem  = yrem_ff;
   assign dn_ya    = ya_ff;
   assign dn_side  = side_ff;

endmodule

[sv/pdnc_out.sv]
// Result stage: sign fix, saturation, clip sentinel and nudge, output register.
module pdnc_out import pdnc_pkg::*; #(
   parameter int W = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [W-1:0]       in_qx,
   input  logic [W-1:0]       in_qy,
   input  side_type           in_side,
   input  logic               clip_enable,
   input  logic [REG_W-1:0]   clip_marker,
   input  logic [REG_W-1:0]   clip_nudge,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [REG_W-1:0]   out_x,
   output logic [REG_W-1:0]   out_y,
   output logic [DEPTH_W-1:0] out_depth,
   output logic               out_clipped,
   output logic               out_div_zero,
   output logic               out_last
);

   localparam logic [W-1:0] QMAX = {1'b0, {(W-1){1'b1}}};

   logic                valid_ff;
   logic [REG_W-1:0]    x_ff, y_ff;
   logic [DEPTH_W-1:0]  depth_ff;
   logic                clipped_ff, div_zero_ff, last_ff;

   logic signed [W-1:0] sx_w, sy_w;
   logic [REG_W-1:0]    sx32, sy32, x_in;

   function automatic logic [W-1:0] fix_sign(input logic [W-1:0] q, input logic neg);
      logic [W-1:0] r;
      if (neg)           r = ~q + 1'b1;
      else if (q[W-1])   r = QMAX;      // most negative over minus one
      else               r = q;
      return r;
   endfunction

   always_comb begin
      sx_w = in_side.zero_div ? '0 : fix_sign(in_qx, in_side.neg_x);
      sy_w = in_side.zero_div ? '0 : fix_sign(in_qy, in_side.neg_y);
      sx32 = REG_W'(sx_w);
      sy32 = REG_W'(sy_w);
      if (in_side.clip)
         x_in = clip_marker;
      else if (clip_enable && sx32 == clip_marker)
         x_in = clip_nudge;
      else
         x_in = sx32;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         x_ff        <= x_in;
         y_ff        <= sy32;
         depth_ff    <= in_side.depth;
         clipped_ff  <= in_side.clip;
         div_zero_ff <= in_side.zero_div;
         last_ff     <= in_side.last;
      end
   end

   assign out_valid    = valid_ff;
   assign out_x        = x_ff;
   assign out_y        = y_ff;
   assign out_depth    = depth_ff;
   assign out_clipped  = clipped_ff;
   assign out_div_zero = div_zero_ff;
   assign out_last     = last_ff;

endmodule

[sv/perspective_divide_near_clip_unit.sv]
// Top level of the perspective divide / near clip unit.
//
// Usage:
//  - req_ carries one vertex per beat: tdata = x_num, y_num, z_in (32 bits
//    each, low bits first), tlast marks the last vertex of a range.
//  - rsp_ returns one result beat per vertex, in order: screen_x, screen_y,
//    33-bit depth_out in tdata; tuser holds clipped and div_zero; tlast
//    copies the input tlast.
//  - csr_ writes registers 0..4 (clip_enable, near_plane, depth_offset,
//    clip_marker, clip_nudge); the user must write them only while no
//    vertex is in flight, as the block itself does not enforce it.
//  - Throughput: one vertex per clock while rsp_tready stays high. Divider
//    chain: COORD_WIDTH cells, one quotient bit each, then a result register.
//  - Each cell holds its own valid bit; when rsp_tready is low the stall
//    ripples back only as far as the first empty cell, so bubbles are
//    squeezed out and req_tready stays high until the chain is full.
//  - Reset (synchronous, active high) empties the chain and output and
//    restores the register defaults.
module perspective_divide_near_clip_unit import pdnc_pkg::*; #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   // csr
   input  logic                csr_we,
   input  logic [ADDR_W-1:0]   csr_addr,
   input  logic [REG_W-1:0]    csr_wdata,
   // vertex in
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [95:0]         req_tdata,   // x_num[31:0], y_num[63:32], z_in[95:64]
   input  logic                req_tlast,
   // result out
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [103:0]        rsp_tdata,   // screen_x[31:0], screen_y[63:32],
                                            // depth_out[96:64], zero pad [103:97]
   output logic [1:0]          rsp_tuser,   // clipped[0], div_zero[1]
   output logic                rsp_tlast
);

   localparam int W = COORD_WIDTH;

   // ---------------- configuration registers
   logic             clip_enable_ff;
   logic [REG_W-1:0] near_plane_ff, depth_offset_ff, clip_marker_ff, clip_nudge_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_enable_ff  <= RST_CLIP_ENABLE;
         near_plane_ff   <= RST_NEAR_PLANE;
         depth_offset_ff <= RST_DEPTH_OFFSET;
         clip_marker_ff  <= RST_CLIP_MARKER;
         clip_nudge_ff   <= RST_CLIP_NUDGE;
      end else if (csr_we) begin
         case (reg_index_type'(csr_addr))
            REG_CLIP_ENABLE:  clip_enable_ff  <= csr_wdata[0];
            REG_NEAR_PLANE:   near_plane_ff   <= csr_wdata;
            REG_DEPTH_OFFSET: depth_offset_ff <= csr_wdata;
            REG_CLIP_MARKER:  clip_marker_ff  <= csr_wdata;
            REG_CLIP_NUDGE:   clip_nudge_ff   <= csr_wdata;
            default: ;        // unknown index: ignored
         endcase
      end
   end

   // ---------------- entry: narrow operands, clip test, depth, magnitudes
   logic signed [W-1:0]       xw, yw, zw;
   logic signed [REG_W-1:0]   zs;
   logic signed [DEPTH_W-1:0] depth_s;
   logic                      clip_hit;
   logic [W-1:0]              xmag, ymag, zmag, div_in;
   side_type                  side_in;

   assign xw = req_tdata[W-1:0];
   assign yw = req_tdata[32+W-1:32];
   assign zw = req_tdata[64+W-1:64];
   assign zs = REG_W'(zw);

   always_comb begin
      clip_hit = clip_enable_ff && (zs < signed'(near_plane_ff));
      depth_s  = DEPTH_W'(zs) - DEPTH_W'(signed'(depth_offset_ff));
      xmag     = xw[W-1] ? (~xw + 1'b1) : xw;
      ymag     = yw[W-1] ? (~yw + 1'b1) : yw;
      zmag     = zw[W-1] ? (~zw + 1'b1) : zw;
      // a clipped vertex divides y by one so the chain hands y back unchanged
      div_in   = clip_hit ? W'(1) : zmag;
      side_in.neg_x    = xw[W-1] ^ zw[W-1];
      side_in.neg_y    = clip_hit ? yw[W-1] : (yw[W-1] ^ zw[W-1]);
      side_in.zero_div = !clip_hit && (zw == '0);
      side_in.clip     = clip_hit;
      side_in.last     = req_tlast;
      side_in.depth    = depth_s;
   end

   // ---------------- divider chain
   logic         c_valid [W+1];
   logic         c_ready [W+1];
   logic [W-1:0] c_div   [W+1];
   logic [W-1:0] c_xrem  [W+1];
   logic [W-1:0] c_xa    [W+1];
   logic [W-1:0] c_yrem  [W+1];
   logic [W-1:0] c_ya    [W+1];
   side_type     c_side  [W+1];

   assign c_valid[0] = req_tvalid;
   assign req_tready = c_ready[0];
   assign c_div[0]   = div_in;
   assign c_xrem[0]  = '0;
   assign c_xa[0]    = xmag;
   assign c_yrem[0]  = '0;
   assign c_ya[0]    = ymag;
   assign c_side[0]  = side_in;

   for (genvar i = 0; i < W; i++) begin : g_cell
      pdnc_cell #(.W(W)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (c_valid[i]),
         .up_ready (c_ready[i]),
         .up_div   (c_div[i]),
         .up_xrem  (c_xrem[i]),
         .up_xa    (c_xa[i]),
         .up_yrem  (c_yrem[i]),
         .up_ya    (c_ya[i]),
         .up_side  (c_side[i]),
         .dn_valid (c_valid[i+1]),
         .dn_ready (c_ready[i+1]),
         .dn_div   (c_div[i+1]),
         .dn_xrem  (c_xrem[i+1]),
         .dn_xa    (c_xa[i+1]),
         .dn_yrem  (c_yrem[i+1]),
         .dn_ya    (c_ya[i+1]),
         .dn_side  (c_side[i+1])
      );
   end

   // ---------------- result stage
   logic [REG_W-1:0]   out_x, out_y;
   logic [DEPTH_W-1:0] out_depth;
   logic               out_clipped, out_div_zero;

   pdnc_out #(.W(W)) u_out (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (c_valid[W]),
      .in_ready     (c_ready[W]),
      .in_qx        (c_xa[W]),
      .in_qy        (c_ya[W]),
      .in_side      (c_side[W]),
      .clip_enable  (clip_enable_ff),
      .clip_marker  (clip_marker_ff),
      .clip_nudge   (clip_nudge_ff),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_x        (out_x),
      .out_y        (out_y),
      .out_depth    (out_depth),
      .out_clipped  (out_clipped),
      .out_div_zero (out_div_zero),
      .out_last     (rsp_tlast)
   );

   // final remainders and divisor are not needed past the chain
   logic unused_tail;
   assign unused_tail = ^{c_div[W], c_xrem[W], c_yrem[W]};

   assign rsp_tdata = {7'd0, out_depth, out_y, out_x};
   assign rsp_tuser = {out_div_zero, out_clipped};

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the perspective divide / near clip unit.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pdnc_pkg::*;

   localparam int COORD_WIDTH   = 32;
   localparam int PIPE_LATENCY  = COORD_WIDTH + 1;  // divider cells plus output register
   localparam int STALL_LIMIT   = 2000;             // cycles with no beat before giving up
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_VERTS   = 128;

   localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;

   // first address past the register file; writes there must be dropped
   localparam logic [ADDR_W-1:0] REG_SPARE_LO = 3'd5;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic               last;
   } vertex_type;

   typedef struct packed {
      logic [31:0] screen_x;
      logic [31:0] screen_y;
      logic [32:0] depth;
      logic        clipped;
      logic        div_zero;
      logic        last;
   } proj_result_type;

   // shadow copy of the register file, updated on every csr write
   typedef struct {
      bit                 clip_en;
      logic signed [31:0] near_z;
      logic signed [31:0] offset;
      logic signed [31:0] marker;
      logic signed [31:0] nudge;
   } proj_cfg_type;

   typedef enum bit {ROW_CSR, ROW_VERTEX} row_kind_type;

   // one line of the directed script: either a register write or a vertex,
   // the latter optionally with its expected result typed in
   typedef struct {
      row_kind_type      kind;
      logic [ADDR_W-1:0] addr;
      logic [31:0]       wdata;
      vertex_type        vtx;
      bit                typed;
      proj_result_type   res;
   } script_row_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          csr_we = 1'b0;
   logic [ADDR_W-1:0] csr_addr = '0;
   logic [REG_W-1:0]  csr_wdata = '0;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [95:0]   req_tdata = '0;   // x_num[31:0], y_num[63:32], z_in[95:64]
   logic          req_tlast = 1'b0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [103:0]  rsp_tdata;        // screen_x[31:0], screen_y[63:32], depth_out[96:64]
   logic [1:0]    rsp_tuser;        // clipped[0], div_zero[1]
   logic          rsp_tlast;

   proj_cfg_type     cfg = '{RST_CLIP_ENABLE, RST_NEAR_PLANE, RST_DEPTH_OFFSET,
                             RST_CLIP_MARKER, RST_CLIP_NUDGE};
   proj_result_type  pending_results[$];
   script_row_type   script[$];
   bit            idling = 1'b1;    // gaps and stalls on or off for the current phase
   int            errors = 0;
   int            quiet_cycles = 0;

   perspective_divide_near_clip_unit #(.COORD_WIDTH(COORD_WIDTH)) uut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Signed divide, truncating toward zero. Only MIN / -1 can overflow,
   // and it clamps to the largest positive coordinate.
   function automatic longint trunc_quot(input longint a, input longint b);
      longint q;
      q = a / b;
      if (q > longint'(COORD_MAX)) q = COORD_MAX;
      return q;
   endfunction

   function automatic proj_result_type project_vertex(input vertex_type v);
      proj_result_type r;
      longint qx, qy;
      r = '0;
      r.last  = v.last;
      r.depth = 33'(longint'(v.z) - longint'(cfg.offset));
      if (cfg.clip_en && v.z < cfg.near_z) begin
         // behind the near plane: no divide, marker x, raw y
         r.clipped = 1'b1;
         qx = cfg.marker;
         qy = v.y;
      end else begin
         if (v.z == 0) begin
            qx = 0;
            qy = 0;
            r.div_zero = 1'b1;
         end else begin
            qx = trunc_quot(v.x, v.z);
            qy = trunc_quot(v.y, v.z);
         end
         // a real x that collides with the marker gets nudged off it
         if (cfg.clip_en && 32'(qx) == cfg.marker) qx = cfg.nudge;
      end
      r.screen_x = 32'(qx);
      r.screen_y = 32'(qy);
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Idle length for either side: mostly none, some short, a few long.
   function automatic int idle_len();
      int r;
      if (!idling) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Operand or register value: extremes, zero, a small signed value or
   // a fully random word.
   function automatic logic signed [31:0] pick_word(input int span);
      case ($urandom_range(0, 7))
         0:       return COORD_MIN;
         1:       return COORD_MAX;
         2:       return '0;
         3, 4, 5: return 32'($urandom_range(0, 2 * span)) - 32'(span);
         default: return $urandom;
      endcase
   endfunction

   function automatic vertex_type random_vertex();
      vertex_type v;
      longint     prod;
      v.x    = pick_word(1000);
      v.y    = pick_word(1000);
      v.z    = pick_word(64);
      v.last = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 7))
         0: v.z = cfg.near_z + 32'($urandom_range(0, 2)) - 32'sd1;  // straddle near plane
         1: begin  // overflowing quotient
            v.x = COORD_MIN;
            v.z = -32'sd1;
         end
         2, 3: begin  // land x/z exactly on the marker
            prod = longint'(cfg.marker) * longint'(v.z);
            if (v.z != 0 && prod >= longint'(COORD_MIN) && prod <= longint'(COORD_MAX))
               v.x = 32'(prod);
         end
         default: ;
      endcase
      return v;
   endfunction

   function automatic script_row_type csr_row(input logic [ADDR_W-1:0] a,
                                              input logic [31:0] d);
      script_row_type s;
      s.kind  = ROW_CSR;
      s.addr  = a;
      s.wdata = d;
      s.vtx   = '{default: '0};
      s.typed = 1'b0;
      s.res   = '0;
      return s;
   endfunction

   function automatic script_row_type vtx_row(input logic signed [31:0] x, y, z,
                                              input logic last);
      script_row_type s;
      s.kind  = ROW_VERTEX;
      s.addr  = '0;
      s.wdata = '0;
      s.vtx   = '{x, y, z, last};
      s.typed = 1'b0;
      s.res   = '0;
      return s;
   endfunction

   function automatic script_row_type typed_row(input logic signed [31:0] x, y, z,
                                                input logic last,
                                                input logic [31:0] sx, sy,
                                                input logic [32:0] depth,
                                                input logic clp, dz);
      script_row_type s;
      s = vtx_row(x, y, z, last);
      s.typed = 1'b1;
      s.res   = '{sx, sy, depth, clp, dz, last};
      return s;
   endfunction

   // Register write: one cycle with csr_we high, shadow updated at the edge.
   task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
      case (addr)
         REG_CLIP_ENABLE:  cfg.clip_en = data[0];
         REG_NEAR_PLANE:   cfg.near_z  = data;
         REG_DEPTH_OFFSET: cfg.offset  = data;
         REG_CLIP_MARKER:  cfg.marker  = data;
         REG_CLIP_NUDGE:   cfg.nudge   = data;
         default: ;  // past the register file, dropped
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Offer one vertex beat, after a random gap, and log its expected result
   // once it is taken.
   task automatic send_vertex(input vertex_type v, input bit typed,
                              input proj_result_type res);
      int gap;
      gap = idle_len();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {v.z, v.y, v.x};
      req_tlast  <= v.last;
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(typed ? res : project_vertex(v));
   endtask

   // Stop sending and wait for every outstanding result. Each vertex yields
   // exactly one result, so an empty queue means an empty divider chain.
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Result side: random backpressure and the scoreboard
   // ---------------------------------------------------------------------

   initial begin : rsp_backpressure
      int hold;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            hold--;
         end else begin
            rsp_tready <= 1'b1;
            hold = idle_len();
         end
      end
   end

   always @(posedge clock) begin : result_check
      proj_result_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.screen_x = rsp_tdata[31:0];
         got.screen_y = rsp_tdata[63:32];
         got.depth    = rsp_tdata[96:64];
         got.clipped  = rsp_tuser[0];
         got.div_zero = rsp_tuser[1];
         got.last     = rsp_tlast;
         if (pending_results.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t: result beat with nothing expected: x=%h y=%h depth=%h",
                        $realtime, got.screen_x, got.screen_y, got.depth);
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               errors++;
               if (errors <= 10) begin
                  $display("%0t: result mismatch", $realtime);
                  $display("   expected x=%h y=%h depth=%h clipped=%b div_zero=%b last=%b",
                           want.screen_x, want.screen_y, want.depth,
                           want.clipped, want.div_zero, want.last);
                  $display("   actual   x=%h y=%h depth=%h clipped=%b div_zero=%b last=%b",
                           got.screen_x, got.screen_y, got.depth,
                           got.clipped, got.div_zero, got.last);
               end
            end
         end
      end
   end

   // Watchdog: a correct run never goes this long without a beat on either side.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------

   initial begin : main_seq
      // Directed script. Phase 1 runs on the reset register values:
      // clipping on, near plane 1, no offset, marker -5000, nudge -5001.
      script.push_back(typed_row(100, 50, 10, 0, 10, 5, 33'd10, 0, 0));
      // zero depth is below the near plane here, so it clips rather than faults
      script.push_back(typed_row(7, -3, 0, 0, -32'sd5000, -32'sd3, 33'd0, 1, 0));
      script.push_back(typed_row(1, 2, -5, 1, -32'sd5000, 2, 33'h1_FFFF_FFFB, 1, 0));
      // quotient equals the marker: nudged
      script.push_back(typed_row(-50000, 0, 10, 0, -32'sd5001, 0, 33'd10, 0, 0));
      script.push_back(typed_row(COORD_MAX, COORD_MIN, 1, 0,
                                 COORD_MAX, COORD_MIN, 33'd1, 0, 0));
      script.push_back(typed_row(COORD_MAX, COORD_MIN, COORD_MAX, 1,
                                 1, -32'sd1, 33'h0_7FFF_FFFF, 0, 0));
      script.push_back(typed_row(COORD_MIN, COORD_MAX, COORD_MIN, 0,
                                 -32'sd5000, COORD_MAX, 33'h1_8000_0000, 1, 0));
      // depth right on the near plane is not clipped
      script.push_back(typed_row(-7, 7, 1, 0, -32'sd7, 7, 33'd1, 0, 0));
      // truncation toward zero
      script.push_back(typed_row(-9, 9, 2, 1, -32'sd4, 4, 33'd2, 0, 0));
      script.push_back(vtx_row(123456789, -987654, 321, 0));
      script.push_back(vtx_row(-123456789, 987654, -321, 1));

      // Phase 2: plain divide; upper write bits must not leak into the enable.
      script.push_back(csr_row(REG_CLIP_ENABLE, 32'hFFFF_FFFE));
      script.push_back(typed_row(COORD_MIN, COORD_MIN, -1, 0,
                                 COORD_MAX, COORD_MAX, 33'h1_FFFF_FFFF, 0, 0));
      script.push_back(typed_row(123, -1, 0, 1, 0, 0, 33'd0, 0, 1));
      script.push_back(typed_row(-50000, 0, 10, 0, -32'sd5000, 0, 33'd10, 0, 0));
      script.push_back(typed_row(100, -100, -5, 0, -32'sd20, 20, 33'h1_FFFF_FFFB, 0, 0));
      script.push_back(typed_row(COORD_MIN, COORD_MAX, COORD_MIN, 1,
                                 1, 0, 33'h1_8000_0000, 0, 0));

      // Phase 3: zero depth is not clipped, and its zero x hits a zero marker.
      script.push_back(csr_row(REG_CLIP_ENABLE, 32'd1));
      script.push_back(csr_row(REG_NEAR_PLANE, 32'd0));
      script.push_back(csr_row(REG_DEPTH_OFFSET, COORD_MIN));
      script.push_back(csr_row(REG_CLIP_MARKER, 32'd0));
      script.push_back(csr_row(REG_CLIP_NUDGE, 32'd77));
      script.push_back(csr_row(REG_SPARE_LO, 32'hFFFF_FFFF));
      script.push_back(vtx_row(1, 5, 0, 0));
      script.push_back(vtx_row(COORD_MIN, 3, COORD_MAX, 0));
      script.push_back(vtx_row(4, -4, -1, 1));

      // Phase 4: nothing clips, saturated quotient lands on the marker,
      // and the depth difference reaches its negative extreme.
      script.push_back(csr_row(REG_NEAR_PLANE, COORD_MIN));
      script.push_back(csr_row(REG_DEPTH_OFFSET, COORD_MAX));
      script.push_back(csr_row(REG_CLIP_MARKER, COORD_MAX));
      script.push_back(csr_row(REG_CLIP_NUDGE, COORD_MIN));
      script.push_back(vtx_row(COORD_MIN, COORD_MIN, -1, 0));
      script.push_back(vtx_row(COORD_MAX, 0, COORD_MIN, 1));

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].kind == ROW_CSR) begin
            drain();
            write_reg(script[i].addr, script[i].wdata);
         end else
            send_vertex(script[i].vtx, script[i].typed, script[i].res);
      end

      // Random phases, each on a fresh register setting. Every third phase
      // runs both sides flat out.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         drain();
         idling = (p % 3 != 2);
         write_reg(REG_CLIP_ENABLE, $urandom);
         write_reg(REG_NEAR_PLANE, pick_word(100));
         write_reg(REG_DEPTH_OFFSET, pick_word(1 << 20));
         write_reg(REG_CLIP_MARKER, pick_word(50));
         write_reg(REG_CLIP_NUDGE, pick_word(50));
         if ($urandom_range(0, 2) == 0)
            write_reg(REG_SPARE_LO + 3'($urandom_range(0, 2)), $urandom);
         for (int i = 0; i < PHASE_VERTS; i++)
            send_vertex(random_vertex(), 1'b0, '0);
      end

      drain();
      repeat (PIPE_LATENCY + 8) @(posedge clock);
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

[filelist.f]
sv/pdnc_pkg.sv
sv/pdnc_cell.sv
sv/pdnc_out.sv
sv/perspective_divide_near_clip_unit.sv
verif/tb_top.sv
